// ===== rtl/tbsr_pkg.sv =====
// Shared constants, types and the completion-count table of the bracket sequence ranker.
package tbsr_pkg;

    localparam int MaxHalf  = 20;
    localparam int RankW    = 53;
    localparam int SymW     = 2;
    localparam int HalfW    = 5;
    localparam int PosW     = 6;
    localparam int DepthW   = 5;
    localparam int IdxW     = 5;

    localparam logic [DepthW-1:0] DepthSat = 5'd31;
    localparam logic [DepthW-1:0] DepthCap = 5'(MaxHalf);
    localparam logic [HalfW-1:0]  HalfMin  = 5'd1;
    localparam logic [HalfW-1:0]  HalfMax  = 5'(MaxHalf);
    localparam logic [HalfW-1:0]  HalfRst  = 5'd1;

    // Symbol order is the rank order: ( < ) < [ < ].
    localparam logic [SymW-1:0] SymOpenRound   = 2'd0;
    localparam logic [SymW-1:0] SymCloseRound  = 2'd1;
    localparam logic [SymW-1:0] SymOpenSquare  = 2'd2;
    localparam logic [SymW-1:0] SymCloseSquare = 2'd3;

    // Entry [t][m]: balanced completions of 2m+t symbols ending at balance t,
    // i.e. ballot count times 2^m, wrapped to the rank width.
    typedef logic [MaxHalf:0][MaxHalf-1:0][RankW-1:0] t_term_table;

    typedef struct packed {
        logic               use_a;
        logic               dbl_a;
        logic [IdxW-1:0]    t_a;
        logic [IdxW-1:0]    m_a;
        logic               use_b;
        logic [IdxW-1:0]    t_b;
        logic [IdxW-1:0]    m_b;
        logic               last;
    } t_index_stage;

    typedef struct packed {
        logic [RankW-1:0]   term_a;
        logic [RankW-1:0]   term_b;
        logic               last;
    } t_term_stage;

    function automatic t_term_table build_term_table();
        logic [63:0]  cur [0:2*MaxHalf];
        logic [63:0]  nxt [0:2*MaxHalf];
        logic [63:0]  shifted;
        t_term_table  tab;
        int           len;
        int           h;
        int           m;
        tab = '0;
        for (h = 0; h <= 2 * MaxHalf; h++) begin
            cur[h] = 64'd0;
            nxt[h] = 64'd0;
        end
        cur[0] = 64'd1;
        for (len = 0; len < 2 * MaxHalf; len++) begin
            for (h = 0; h <= MaxHalf; h++) begin
                if (h <= len && ((len - h) % 2) == 0) begin
                    m = (len - h) / 2;
                    if (m < MaxHalf) begin
                        shifted   = cur[h] << m;
                        tab[h][m] = shifted[RankW-1:0];
                    end
                end
            end
            for (h = 0; h <= 2 * MaxHalf; h++) begin
                nxt[h] = 64'd0;
                if (h > 0) nxt[h] = nxt[h] + cur[h-1];
                if (h < 2 * MaxHalf) nxt[h] = nxt[h] + cur[h+1];
            end
            for (h = 0; h <= 2 * MaxHalf; h++) begin
                cur[h] = nxt[h];
            end
        end
        return tab;
    endfunction

    localparam t_term_table TermTable = build_term_table();

endpackage

// ===== rtl/tbsr_ifs.sv =====
// Valid/ready channel interfaces of the bracket sequence ranker.
interface tbsr_sym_if;
    logic       valid;
    logic       ready;
    logic [1:0] symbol;
    modport source (output valid, output symbol, input ready);
    modport sink   (input valid, input symbol, output ready);
endinterface

interface tbsr_rank_if;
    logic        valid;
    logic        ready;
    logic [52:0] rank;
    modport source (output valid, output rank, input ready);
    modport sink   (input valid, input rank, output ready);
endinterface

interface tbsr_cfg_if;
    logic       valid;
    logic       ready;
    logic [4:0] half_length;
    modport source (output valid, output half_length, input ready);
    modport sink   (input valid, input half_length, output ready);
endinterface

// ===== rtl/two_type_bracket_sequence_ranker_core.sv =====
// Top level: lexicographic ranker of balanced sequences over ( ) [ ].
//
// Usage:
//   i_cfg  - write channel for half_length (number of bracket pairs). Always
//            ready. Write only while the block is idle; a write starts a new
//            sequence. Values 0 and above 20 act as 1 and 20.
//   i_sym  - one bracket item per handshake, codes 0 '(' 1 ')' 2 '[' 3 ']'.
//   o_rank - one item per sequence: the zero-based rank, after the last symbol
//            of a sequence of 2*half_length symbols.
// Throughput: one symbol per cycle while no finished rank waits on a full output
//   register. Each symbol needs two lookups of a constant completion table, a shift
//   by one and a three-input 53-bit add, spread over three register stages (index,
//   table term, sum). The rank passes from the last accepted symbol through these
//   registers to o_rank, unless an earlier rank still waits in the output register.
// Stall: a waiting result sits in the output register; symbols keep flowing
//   and accumulating until another finished rank needs that register.
// Reset: half_length = 1, position, depth and rank cleared, pipeline empty.
module two_type_bracket_sequence_ranker_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tbsr_cfg_if.sink      i_cfg,
    tbsr_sym_if.sink      i_sym,
    tbsr_rank_if.source   o_rank
);
    import tbsr_pkg::*;

    // Sequence state
    logic [HalfW-1:0]   r_half;
    logic [PosW-1:0]    r_pos,   n_pos;
    logic [DepthW-1:0]  r_depth, n_depth;
    logic [MaxHalf-1:0] r_stack;   // open bracket types, 1 = square

    // Pipeline
    logic               r_s1_valid;
    t_index_stage       r_s1,  n_s1;
    logic               r_s2_valid;
    t_term_stage        r_s2,  n_s2;
    logic [RankW-1:0]   r_rank, n_rank;
    logic               r_out_valid;
    logic [RankW-1:0]   r_out_rank;

    logic               sym_acc;
    logic               s1_go;
    logic               s2_go;
    logic               out_free;

    logic [HalfW-1:0]   eff_half;
    logic [PosW-1:0]    two_half;
    logic [PosW-1:0]    left;
    logic [PosW-1:0]    pos_inc;
    logic [PosW-1:0]    tgt_a, tgt_b;
    logic [PosW-1:0]    diff_a, diff_b;
    logic               ok_a, ok_b;
    logic               top_round;
    logic [IdxW-1:0]    top_idx;
    logic [SymW-1:0]    sym;
    logic [RankW-1:0]   look_a, look_b;

    // Handshakes: the last stage stalls only when a finished rank meets a full
    // output register.
    assign out_free      = !r_out_valid || o_rank.ready;
    assign s2_go         = r_s2_valid && (!r_s2.last || out_free);
    assign s1_go         = r_s1_valid && (!r_s2_valid || s2_go);
    assign i_sym.ready   = !r_s1_valid || s1_go;
    assign sym_acc       = i_sym.valid && i_sym.ready;
    assign i_cfg.ready   = 1'b1;
    assign o_rank.valid  = r_out_valid;
    assign o_rank.rank   = r_out_rank;
    assign sym           = i_sym.symbol;

    // Stage 0: clamp length, find remaining symbols and candidate balances.
    always_comb begin
        if (r_half < HalfMin) begin
            eff_half = HalfMin;
        end else if (r_half > HalfMax) begin
            eff_half = HalfMax;
        end else begin
            eff_half = r_half;
        end
        two_half = {eff_half, 1'b0};
        left     = two_half - r_pos - 6'd1;
        pos_inc  = r_pos + 6'd1;

        top_idx   = r_depth - 5'd1;
        top_round = (r_depth != 5'd0) && (r_depth <= DepthCap) && !r_stack[top_idx];

        // Balance after an opening bracket and after a closing bracket.
        tgt_a  = {1'b0, r_depth} + 6'd1;
        tgt_b  = {1'b0, r_depth} - 6'd1;
        diff_a = left - tgt_a;
        diff_b = left - tgt_b;
        ok_a   = (tgt_a <= {1'b0, eff_half}) && (tgt_a <= left) && !diff_a[0];
        ok_b   = (r_depth != 5'd0) && (tgt_b <= {1'b0, eff_half})
                 && (tgt_b <= left) && !diff_b[0];

        n_s1.use_a = ok_a && (sym != SymOpenRound);
        n_s1.dbl_a = (sym == SymCloseSquare);
        n_s1.t_a   = tgt_a[IdxW-1:0];
        n_s1.m_a   = diff_a[PosW-1:1];
        n_s1.use_b = ok_b && top_round
                     && ((sym == SymOpenSquare) || (sym == SymCloseSquare));
        n_s1.t_b   = tgt_b[IdxW-1:0];
        n_s1.m_b   = diff_b[PosW-1:1];
        n_s1.last  = (pos_inc >= two_half);

        // Advance depth and position; the last symbol restarts the sequence.
        if (sym[0]) begin
            n_depth = (r_depth != 5'd0) ? r_depth - 5'd1 : r_depth;
        end else begin
            n_depth = (r_depth < DepthSat) ? r_depth + 5'd1 : r_depth;
        end
        n_pos = pos_inc;
        if (n_s1.last) begin
            n_depth = '0;
            n_pos   = '0;
        end
    end

    // Stage 1: table lookups.
    always_comb begin
        look_a = TermTable[r_s1.t_a][r_s1.m_a];
        look_b = TermTable[r_s1.t_b][r_s1.m_b];
        n_s2.term_a = '0;
        if (r_s1.use_a) begin
            n_s2.term_a = r_s1.dbl_a ? {look_a[RankW-2:0], 1'b0} : look_a;
        end
        n_s2.term_b = r_s1.use_b ? look_b : '0;
        n_s2.last   = r_s1.last;
    end

    // Stage 2: accumulate.
    assign n_rank = r_rank + r_s2.term_a + r_s2.term_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half      <= HalfRst;
            r_pos       <= '0;
            r_depth     <= '0;
            r_stack     <= '0;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_rank      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                // Start a new sequence with the new length.
                r_half  <= i_cfg.half_length;
                r_pos   <= '0;
                r_depth <= '0;
                r_rank  <= '0;
            end else begin
                if (sym_acc) begin
                    r_pos   <= n_pos;
                    r_depth <= n_depth;
                    if (!sym[0] && (r_depth < DepthCap)) begin
                        r_stack[r_depth] <= (sym == SymOpenSquare);
                    end
                end
                if (s2_go) begin
                    r_rank <= r_s2.last ? '0 : n_rank;
                end
            end

            if (sym_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end

            if (s1_go) begin
                r_s2_valid <= 1'b1;
            end else if (s2_go) begin
                r_s2_valid <= 1'b0;
            end

            if (s2_go && r_s2.last) begin
                r_out_valid <= 1'b1;
            end else if (o_rank.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (sym_acc) begin
            r_s1 <= n_s1;
        end
        if (s1_go) begin
            r_s2 <= n_s2;
        end
        if (s2_go && r_s2.last) begin
            r_out_rank <= n_rank;
        end
    end

    // Position never reaches the end of a sequence between symbols.
    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos < two_half)
        else $error("position beyond sequence length");

    // A finished rank leaves the accumulator cleared for the next sequence.
    a_rank_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s2_go && r_s2.last) |=> (r_rank == '0))
        else $error("rank not cleared after last symbol");

    // A new result appears only from a last item leaving the term stage.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_s2_valid && r_s2.last))
        else $error("result without last symbol");

    // The last symbol of a sequence restarts position and depth.
    a_last_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (sym_acc && n_s1.last && !i_cfg.valid) |=> (r_pos == '0 && r_depth == '0))
        else $error("sequence state not restarted");

endmodule

// ===== bench/two_type_bracket_sequence_ranker_core_tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench of the bracket sequence ranker: directed and random sequences vs a rank predictor.
module two_type_bracket_sequence_ranker_core_tb;
    import tbsr_pkg::*;

    localparam int WatchdogLimit = 2000;   // cycles with no handshake at all
    localparam int DrainCycles   = 8;      // pipeline is three stages deep
    localparam int RandomItems   = 2000;
    localparam int ResetCycles   = 5;

    typedef enum int {
        SeqBalanced,
        SeqBroken,
        SeqNoise,
        SeqDeep
    } t_seq_kind;

    logic i_clk = 1'b0;
    logic i_rst_n;

    tbsr_cfg_if  cfg_if ();
    tbsr_sym_if  sym_if ();
    tbsr_rank_if rank_if ();

    two_type_bracket_sequence_ranker_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_sym   (sym_if),
        .o_rank  (rank_if)
    );

    // Predictor state: the bench's own copy of the ranker registers.
    logic [HalfW-1:0]  pairs_reg;
    logic [RankW-1:0]  rank_acc;
    logic [DepthW-1:0] depth_cnt;
    logic [PosW-1:0]   sym_pos;
    logic              square_open [MaxHalf];

    // path_count[len][h]: paths of len unit steps from 0 to h that never go below 0.
    longint unsigned   path_count [2*MaxHalf][2*MaxHalf+1];

    logic [RankW-1:0]  pending_ranks [$];
    logic [RankW-1:0]  expected_rank;
    int                mismatches   = 0;
    int                items_sent   = 0;
    int                quiet_cycles = 0;
    int                rank_hold    = 0;
    bit                idle_on      = 1'b1;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    //------------------------------------------------------------------
    // Predictor
    //------------------------------------------------------------------
    function automatic void fill_path_counts();
        int len;
        int h;
        for (h = 0; h <= 2 * MaxHalf; h++) path_count[0][h] = 0;
        path_count[0][0] = 1;
        for (len = 1; len < 2 * MaxHalf; len++) begin
            for (h = 0; h <= 2 * MaxHalf; h++) begin
                path_count[len][h] = 0;
                if (h > 0) path_count[len][h] += path_count[len-1][h-1];
                if (h < 2 * MaxHalf) path_count[len][h] += path_count[len-1][h+1];
            end
        end
    endfunction

    function automatic void clear_sequence();
        rank_acc  = '0;
        depth_cnt = '0;
        sym_pos   = '0;
    endfunction

    // Pair count in use: zero acts as one, anything above the capacity as the capacity.
    function automatic int effective_pairs();
        if (pairs_reg < HalfMin) return int'(HalfMin);
        if (pairs_reg > HalfMax) return int'(HalfMax);
        return int'(pairs_reg);
    endfunction

    // Balanced completions of `left` symbols ending at `target`: paths times 2^pairs-closed.
    function automatic logic [RankW-1:0] completion_count(int left, int target, int pairs);
        longint unsigned v;
        if (target < 0 || target > pairs || target > left || left < 0 || left >= 2 * MaxHalf)
            return '0;
        v = path_count[left][target] << ((left - target) / 2);
        return RankW'(v);
    endfunction

    // Advance the predicted ranker by one accepted symbol; queue the rank on the last one.
    function automatic void rank_after_symbol(logic [SymW-1:0] s);
        int pairs;
        int left;
        int d;
        int k;
        int target;
        bit top_round;
        pairs = effective_pairs();
        if (int'(sym_pos) >= 2 * pairs) clear_sequence();
        d         = int'(depth_cnt);
        left      = 2 * pairs - int'(sym_pos) - 1;
        top_round = (d >= 1) && (d <= MaxHalf) && !square_open[d-1];

        // Every smaller symbol counts, except ')' when the innermost open is not round.
        for (k = 0; k < int'(s); k++) begin
            if (k == int'(SymCloseRound) && !top_round) continue;
            target   = (k == int'(SymCloseRound)) ? d - 1 : d + 1;
            rank_acc = rank_acc + completion_count(left, target, pairs);
        end

        if (s == SymCloseRound || s == SymCloseSquare) begin
            // A close at zero depth leaves depth and stack alone.
            if (depth_cnt != '0) depth_cnt--;
        end else begin
            // Past the capacity the type is dropped; depth saturates.
            if (depth_cnt < DepthCap) square_open[depth_cnt] = (s == SymOpenSquare);
            if (depth_cnt < DepthSat) depth_cnt++;
        end

        sym_pos++;
        if (int'(sym_pos) >= 2 * pairs) begin
            pending_ranks.push_back(rank_acc);
            clear_sequence();
        end
    endfunction

    //------------------------------------------------------------------
    // Stimulus builders
    //------------------------------------------------------------------
    function automatic void append_text(ref logic [SymW-1:0] run [$], input string text);
        int i;
        for (i = 0; i < text.len(); i++) begin
            case (text[i])
                "(":     run.push_back(SymOpenRound);
                ")":     run.push_back(SymCloseRound);
                "[":     run.push_back(SymOpenSquare);
                default: run.push_back(SymCloseSquare);
            endcase
        end
    endfunction

    function automatic void append_sequence(ref logic [SymW-1:0] run [$],
                                            input t_seq_kind kind, input int pairs);
        logic [SymW-1:0] seq [$];
        bit              open_sq [$];
        int              len;
        int              p;
        int              d;
        bit              t;
        len = 2 * pairs;
        for (p = 0; p < len; p++) begin
            t = bit'($urandom_range(0, 1));
            case (kind)
                SeqNoise: seq.push_back(SymW'($urandom_range(0, 3)));
                SeqDeep: begin
                    // Mostly opens: drives depth past the stack capacity and into saturation.
                    if ($urandom_range(0, 9) != 0) seq.push_back(t ? SymOpenSquare : SymOpenRound);
                    else seq.push_back(t ? SymCloseSquare : SymCloseRound);
                end
                default: begin
                    // Open only while the rest of the sequence can still close everything.
                    d = open_sq.size();
                    if (d + 1 <= len - p - 1 && (d == 0 || $urandom_range(0, 1) == 1)) begin
                        open_sq.push_back(t);
                        seq.push_back(t ? SymOpenSquare : SymOpenRound);
                    end else begin
                        t = open_sq.pop_back();
                        seq.push_back(t ? SymCloseSquare : SymCloseRound);
                    end
                end
            endcase
        end
        if (kind == SeqBroken) seq[$urandom_range(0, len - 1)] = SymW'($urandom_range(0, 3));
        run = {run, seq};
    endfunction

    //------------------------------------------------------------------
    // Channel drivers
    //------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        mismatches++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Send a run of symbols back to back, with random gaps when idling is on.
    // Valid drops only during those gaps and after the last item of the run.
    task automatic send_run(input logic [SymW-1:0] run [$]);
        int n;
        foreach (run[i]) begin
            if (idle_on && $urandom_range(0, 5) == 0) begin
                sym_if.valid <= 1'b0;
                n = $urandom_range(1, 16);
                repeat (n) @(posedge i_clk);
            end
            sym_if.valid  <= 1'b1;
            sym_if.symbol <= run[i];
            @(posedge i_clk);
            while (!sym_if.ready) @(posedge i_clk);
            rank_after_symbol(run[i]);
            items_sent++;
        end
        sym_if.valid <= 1'b0;
    endtask

    // Wait for every queued rank, then let an unfinished sequence clear the pipeline.
    task automatic drain_block();
        while (pending_ranks.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    task automatic write_half(input logic [HalfW-1:0] v);
        drain_block();
        cfg_if.valid       <= 1'b1;
        cfg_if.half_length <= v;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        cfg_if.valid <= 1'b0;
        // A write also starts a new sequence.
        pairs_reg = v;
        clear_sequence();
    endtask

    // One setting: write it, then send a mix of sequences and maybe a tail that never finishes.
    task automatic run_phase(input logic [HalfW-1:0] half_v, input int n_seq, input bit deep_first);
        logic [SymW-1:0] run [$];
        int              pairs;
        int              i;
        int              pick;
        t_seq_kind       kind;
        write_half(half_v);
        pairs = effective_pairs();
        for (i = 0; i < n_seq; i++) begin
            pick = $urandom_range(0, 9);
            if (deep_first && i == 0) kind = SeqDeep;
            else if (pick <= 5)       kind = SeqBalanced;
            else if (pick <= 7)       kind = SeqBroken;
            else if (pick == 8)       kind = SeqNoise;
            else                      kind = SeqDeep;
            append_sequence(run, kind, pairs);
        end
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 2 * pairs - 1)) run.push_back(SymW'($urandom_range(0, 3)));
        end
        send_run(run);
    endtask

    //------------------------------------------------------------------
    // Tests
    //------------------------------------------------------------------
    // Reset value of one pair: a set of two-symbol words, including closes at zero depth.
    task automatic test_default_pairs();
        logic [SymW-1:0] run [$];
        append_text(run, "()[](]((");
        append_text(run, ")(]][)");
        send_run(run);
    endtask

    // A clamped setting at the low end, then a short two-pair case with the top rank.
    task automatic test_clamped_pairs();
        logic [SymW-1:0] run [$];
        write_half('0);
        append_text(run, "[]()");
        send_run(run);
        run.delete();
        write_half(HalfMin + 5'd1);
        append_text(run, "([])[][]");
        send_run(run);
    endtask

    // Random settings and sequence kinds; the first phase is the all-ones setting, deep first.
    task automatic test_random_sequences();
        logic [HalfW-1:0] half_v;
        int               start;
        start = items_sent;
        run_phase('1, 2, 1'b1);
        while (items_sent - start < RandomItems) begin
            idle_on = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 9))
                0:       half_v = '0;
                1:       half_v = HalfMin;
                2:       half_v = HalfMax;
                3:       half_v = '1;
                4:       half_v = HalfMax + 5'd1;
                5, 6:    half_v = HalfW'($urandom_range(2, 5));
                default: half_v = HalfW'($urandom_range(1, MaxHalf));
            endcase
            run_phase(half_v, $urandom_range(1, 6), 1'b0);
        end
    endtask

    // Last stretch: both sides at full rate.
    task automatic test_steady_stream();
        idle_on = 1'b0;
        run_phase(HalfW'($urandom_range(1, MaxHalf)), 4, 1'b0);
    endtask

    //------------------------------------------------------------------
    // Result side: random stall bursts on ready, and the rank check
    //------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (rank_hold > 0) begin
            rank_hold--;
            rank_if.ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            rank_hold = $urandom_range(0, 15);
            rank_if.ready <= 1'b0;
        end else begin
            rank_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rank_if.valid && rank_if.ready) begin
            if (pending_ranks.size() == 0) begin
                report_mismatch($sformatf("rank %0d with no sequence pending", rank_if.rank));
            end else begin
                expected_rank = pending_ranks.pop_front();
                if (rank_if.rank !== expected_rank)
                    report_mismatch($sformatf("rank %0d, predicted %0d",
                                              rank_if.rank, expected_rank));
            end
        end
    end

    // Watchdog: end the run when no channel has moved an item for too long.
    always @(posedge i_clk) begin
        if ((sym_if.valid && sym_if.ready) || (cfg_if.valid && cfg_if.ready) ||
            (rank_if.valid && rank_if.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WatchdogLimit) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    //------------------------------------------------------------------
    // Sequence of tests
    //------------------------------------------------------------------
    initial begin
        i_rst_n            <= 1'b0;
        sym_if.valid       <= 1'b0;
        sym_if.symbol      <= SymOpenRound;
        cfg_if.valid       <= 1'b0;
        cfg_if.half_length <= HalfRst;
        fill_path_counts();
        pairs_reg = HalfRst;
        clear_sequence();
        foreach (square_open[i]) square_open[i] = 1'b0;

        repeat (ResetCycles) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_default_pairs();
        test_clamped_pairs();
        test_random_sequences();
        test_steady_stream();
        drain_block();

        if (mismatches == 0 && pending_ranks.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
